FILE: rtl/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared constants, types and sequencer states of the pairwise center distance
// block.
// ----------------------------------------------------------------------------
package pcd_pkg;

	localparam int MAX_KEYS   = 64;
	localparam int COORD_BITS = 16;

	// Fixed widths of the port fields.
	localparam int PORT_COORD_W = 16;
	localparam int PORT_IDX_W   = 6;
	localparam int DIST_W       = 17;
	localparam int DIST_MAX     = 131071;

	localparam int ADDR_W = $clog2(MAX_KEYS);
	localparam int CNT_W  = $clog2(MAX_KEYS + 1);
	localparam int SUM_W  = 2 * COORD_BITS + 1;
	localparam int ROOT_W = COORD_BITS + 1;
	localparam int WIDE_W = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;

	typedef logic [PORT_COORD_W-1:0] pcoord_t;
	typedef logic [PORT_IDX_W-1:0]   oidx_t;
	typedef logic [COORD_BITS-1:0]   coord_t;
	typedef logic [COORD_BITS:0]     csum_t;
	typedef logic [2*COORD_BITS-1:0] prod_t;
	typedef logic [ADDR_W-1:0]       addr_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [SUM_W-1:0]        sq_t;
	typedef logic [SUM_W:0]          iq_t;
	typedef logic [ROOT_W-1:0]       root_t;
	typedef logic [DIST_W-1:0]       dist_t;
	typedef logic [WIDE_W-1:0]       wide_t;

	// Highest power of four that the square root starts from.
	localparam iq_t ISQ_TOP = iq_t'(1) << (2 * COORD_BITS);

	// Write request into the center store.
	typedef struct packed {
		logic   en;
		addr_t  addr;
		coord_t x;
		coord_t y;
	} pcd_wr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SQX,
		ST_SQY,
		ST_START,
		ST_ROOT,
		ST_EMIT
	} seq_state_t;

endpackage

FILE: rtl/pcd_key_if.sv
// ----------------------------------------------------------------------------
// pcd_key_if
// Input channel: one key rectangle per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcd_key_if;
	logic             valid;
	logic             ready;
	logic             first_key;
	pcd_pkg::pcoord_t left_x;
	pcd_pkg::pcoord_t top_y;
	pcd_pkg::pcoord_t right_x;
	pcd_pkg::pcoord_t bottom_y;

	modport source (
		output valid, first_key, left_x, top_y, right_x, bottom_y,
		input  ready
	);
	modport sink (
		input  valid, first_key, left_x, top_y, right_x, bottom_y,
		output ready
	);
endinterface

FILE: rtl/pcd_result_if.sv
// ----------------------------------------------------------------------------
// pcd_result_if
// Output channel: one distance result per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcd_result_if;
	logic           valid;
	logic           ready;
	logic           pair_valid;
	pcd_pkg::oidx_t earlier_index;
	pcd_pkg::oidx_t new_index;
	pcd_pkg::dist_t center_distance;
	logic           key_dropped;
	logic           last;

	modport source (
		output valid, pair_valid, earlier_index, new_index, center_distance,
		       key_dropped, last,
		input  ready
	);
	modport sink (
		input  valid, pair_valid, earlier_index, new_index, center_distance,
		       key_dropped, last,
		output ready
	);
endinterface

FILE: rtl/pcd_store.sv
// ----------------------------------------------------------------------------
// pcd_store
// Center memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pcd_store (
	input  logic             clk,
	input  pcd_pkg::pcd_wr_t wr,
	input  logic             rd_en,
	input  pcd_pkg::addr_t   rd_addr,
	output pcd_pkg::coord_t  rd_x,
	output pcd_pkg::coord_t  rd_y
);

	logic [2*pcd_pkg::COORD_BITS-1:0] mem [pcd_pkg::MAX_KEYS];
	logic [2*pcd_pkg::COORD_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= {wr.x, wr.y};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_x = rd_data_q[2*pcd_pkg::COORD_BITS-1:pcd_pkg::COORD_BITS];
	assign rd_y = rd_data_q[pcd_pkg::COORD_BITS-1:0];

endmodule

FILE: rtl/pcd_isqrt.sv
// ----------------------------------------------------------------------------
// pcd_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pcd_isqrt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  pcd_pkg::sq_t   value,
	output logic           done,
	output pcd_pkg::root_t root
);

	pcd_pkg::iq_t rem_q;
	pcd_pkg::iq_t res_q;
	pcd_pkg::iq_t bit_q;
	pcd_pkg::iq_t trial;
	logic         busy_q;
	logic         done_q;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
			end else if (busy_q && bit_q == pcd_pkg::iq_t'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= pcd_pkg::iq_t'(value);
			res_q <= '0;
			bit_q <= pcd_pkg::ISQ_TOP;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = pcd_pkg::root_t'(res_q);

endmodule

FILE: rtl/pairwise_center_distance_top.sv
// ----------------------------------------------------------------------------
// pairwise_center_distance_top
// Stores the center of each key rectangle and returns the floored distance
// from the new center to every earlier one.
// ----------------------------------------------------------------------------
// Each accepted key that finds room is written into a 64-entry center store;
// a key that is the first of its list, or that finds the list full, yields a
// single word right away. Otherwise one word is produced per earlier key, in
// index order, and each takes a store read, two passes through the shared
// squaring multiplier and COORD_BITS + 1 steps of the iterative square root,
// which sets the rate. The input channel stays busy until the last word of a
// key is loaded. The output word sits in its own register, so the next key is
// taken while the final word of the previous one is still waiting. The store
// needs no clearing after reset.
module pairwise_center_distance_top (
	input  logic         clk,
	input  logic         arst_n,
	pcd_key_if.sink      key,
	pcd_result_if.source result
);

	pcd_pkg::seq_state_t state_q;
	pcd_pkg::seq_state_t state_d;

	pcd_pkg::cnt_t   count_q;
	pcd_pkg::cnt_t   count_eff;
	logic            full;
	pcd_pkg::addr_t  k_q;
	pcd_pkg::addr_t  n_q;
	pcd_pkg::coord_t cx_q;
	pcd_pkg::coord_t cy_q;
	logic            special_q;
	logic            dropped_q;
	pcd_pkg::sq_t    sum_q;

	pcd_pkg::csum_t  sum_x;
	pcd_pkg::csum_t  sum_y;
	pcd_pkg::coord_t cx;
	pcd_pkg::coord_t cy;
	pcd_pkg::pcd_wr_t wr;

	pcd_pkg::coord_t rd_x;
	pcd_pkg::coord_t rd_y;
	pcd_pkg::coord_t dx;
	pcd_pkg::coord_t dy;
	pcd_pkg::coord_t mul_op;
	pcd_pkg::prod_t  prod;

	logic            sqrt_start;
	logic            sqrt_done;
	pcd_pkg::root_t  root;
	pcd_pkg::wide_t  root_w;
	pcd_pkg::dist_t  dist_sat;

	logic            key_acc;
	logic            rd_en;
	logic            load;
	logic            last_word;

	logic            out_valid_q;
	logic            pair_valid_q;
	pcd_pkg::oidx_t  earlier_q;
	pcd_pkg::oidx_t  new_q;
	pcd_pkg::dist_t  dist_q;
	logic            key_dropped_q;
	logic            last_q;

	// Center of the incoming rectangle.
	assign sum_x = pcd_pkg::csum_t'(pcd_pkg::coord_t'(key.left_x))
	             + pcd_pkg::csum_t'(pcd_pkg::coord_t'(key.right_x));
	assign sum_y = pcd_pkg::csum_t'(pcd_pkg::coord_t'(key.top_y))
	             + pcd_pkg::csum_t'(pcd_pkg::coord_t'(key.bottom_y));
	assign cx = sum_x[pcd_pkg::COORD_BITS:1];
	assign cy = sum_y[pcd_pkg::COORD_BITS:1];

	assign key_acc   = key.valid && key.ready;
	assign count_eff = key.first_key ? '0 : count_q;
	assign full      = count_eff >= pcd_pkg::cnt_t'(pcd_pkg::MAX_KEYS);

	always_comb begin
		wr.en   = key_acc && !full;
		wr.addr = count_eff[pcd_pkg::ADDR_W-1:0];
		wr.x    = cx;
		wr.y    = cy;
	end

	pcd_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (k_q),
		.rd_x    (rd_x),
		.rd_y    (rd_y)
	);

	// Shared squaring multiplier: x difference first, then y difference.
	assign dx     = (rd_x > cx_q) ? rd_x - cx_q : cx_q - rd_x;
	assign dy     = (rd_y > cy_q) ? rd_y - cy_q : cy_q - rd_y;
	assign mul_op = (state_q == pcd_pkg::ST_SQX) ? dx : dy;
	assign prod   = pcd_pkg::prod_t'(mul_op) * pcd_pkg::prod_t'(mul_op);

	pcd_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (sum_q),
		.done   (sqrt_done),
		.root   (root)
	);

	assign root_w   = pcd_pkg::wide_t'(root);
	assign dist_sat = (root_w > pcd_pkg::wide_t'(pcd_pkg::DIST_MAX))
	                ? pcd_pkg::dist_t'(pcd_pkg::DIST_MAX)
	                : pcd_pkg::dist_t'(root_w);

	assign last_word = special_q || (k_q == n_q - pcd_pkg::addr_t'(1));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pcd_pkg::ST_IDLE: begin
				if (key_acc) begin
					if (full || count_eff == '0) begin
						state_d = pcd_pkg::ST_EMIT;
					end else begin
						state_d = pcd_pkg::ST_READ;
					end
				end
			end
			pcd_pkg::ST_READ:  state_d = pcd_pkg::ST_SQX;
			pcd_pkg::ST_SQX:   state_d = pcd_pkg::ST_SQY;
			pcd_pkg::ST_SQY:   state_d = pcd_pkg::ST_START;
			pcd_pkg::ST_START: state_d = pcd_pkg::ST_ROOT;
			pcd_pkg::ST_ROOT: begin
				if (sqrt_done) begin
					state_d = pcd_pkg::ST_EMIT;
				end
			end
			pcd_pkg::ST_EMIT: begin
				if (load) begin
					state_d = last_word ? pcd_pkg::ST_IDLE : pcd_pkg::ST_READ;
				end
			end
			default: state_d = pcd_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		key.ready  = 1'b0;
		rd_en      = 1'b0;
		sqrt_start = 1'b0;
		load       = 1'b0;
		unique case (state_q)
			pcd_pkg::ST_IDLE:  key.ready = 1'b1;
			pcd_pkg::ST_READ:  rd_en = 1'b1;
			pcd_pkg::ST_START: sqrt_start = 1'b1;
			pcd_pkg::ST_EMIT:  load = !out_valid_q || result.ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pcd_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (key_acc) begin
				if (!full) begin
					count_q <= count_eff + pcd_pkg::cnt_t'(1);
				end else begin
					count_q <= count_eff;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the current key.
	always_ff @(posedge clk) begin
		if (key_acc) begin
			cx_q      <= cx;
			cy_q      <= cy;
			n_q       <= count_eff[pcd_pkg::ADDR_W-1:0];
			k_q       <= '0;
			special_q <= full || count_eff == '0;
			dropped_q <= full;
		end else if (load && !last_word) begin
			k_q <= k_q + pcd_pkg::addr_t'(1);
		end
		if (state_q == pcd_pkg::ST_SQX) begin
			sum_q <= pcd_pkg::sq_t'(prod);
		end else if (state_q == pcd_pkg::ST_SQY) begin
			sum_q <= sum_q + pcd_pkg::sq_t'(prod);
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (load) begin
			pair_valid_q  <= !special_q;
			earlier_q     <= special_q ? '0 : pcd_pkg::oidx_t'(k_q);
			new_q         <= special_q ? '0 : pcd_pkg::oidx_t'(n_q);
			dist_q        <= special_q ? '0 : dist_sat;
			key_dropped_q <= dropped_q;
			last_q        <= last_word;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.pair_valid      = pair_valid_q;
	assign result.earlier_index   = earlier_q;
	assign result.new_index       = new_q;
	assign result.center_distance = dist_q;
	assign result.key_dropped     = key_dropped_q;
	assign result.last            = last_q;

endmodule
